FILE: rtl/core/rhc_pkg.sv
`timescale 1ns / 1ps
package rhc_pkg;

   localparam int NumLanes = 3;
   localparam int QuoW     = 8;
   localparam int RemW     = 24;
   localparam int DenW     = 16;
   localparam int ChanW    = 8;

   localparam logic DirToHsv = 1'b0;
   localparam logic DirToRgb = 1'b1;

   localparam logic [DenW-1:0] Den255   = 16'd255;
   localparam logic [DenW-1:0] Den65025 = 16'd65025;
   localparam logic [2:0]      SectorSix = 3'd6;

   typedef logic [NumLanes-1:0][RemW-1:0] rem_vec_type;
   typedef logic [NumLanes-1:0][DenW-1:0] den_vec_type;
   typedef logic [NumLanes-1:0][QuoW-1:0] quo_vec_type;

   typedef struct packed {
      logic             dir;
      logic             zero;
      logic [ChanW-1:0] v;
      logic [2:0]       sector;
      logic [ChanW-1:0] alpha;
   } meta_type;

endpackage

FILE: rtl/core/rgb_hsv_color_convert.sv
`timescale 1ns / 1ps
// channel   | dir | handshake        | payload
// req       | in  | tvalid / tready  | tdata: red_or_hue, green_or_saturation, blue_or_value, alpha_in
// rsp       | out | tvalid / tready  | tdata: out_first, out_second, out_third, alpha_out
// csr       | in  | apb psel/penable | direction at byte address 0
// one pixel per clock, except while a result waits at the output
// stages: input, min/max and sector, products, second products, 8 divider steps, output
// the quotients come from a pipelined restoring divider, one quotient bit per stage
// reset clears the valid bits and the direction register
// the whole pipeline holds while a result waits at the output; nothing is dropped
module rgb_hsv_color_convert (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // red_or_hue, green_or_saturation, blue_or_value, alpha_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_first, out_second, out_third, alpha_out
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rhc_pkg::*;

   logic dir_ff;
   logic en;

   logic             s1_valid_ff;
   logic             s1_dir_ff;
   logic [ChanW-1:0] s1_c0_ff, s1_c1_ff, s1_c2_ff, s1_a_ff;

   logic             s2_valid_ff;
   meta_type         s2_meta_ff, s2_meta_in;
   logic [10:0]      s2_n_ff, s2_n_in;
   logic [ChanW-1:0] s2_d_ff, s2_d_in, s2_mx_ff, s2_mx_in;
   logic [ChanW-1:0] s2_s_ff, s2_f_ff, s2_f_in;

   logic             s3_valid_ff;
   meta_type         s3_meta_ff;
   rem_vec_type      s3_num_ff, s3_num_in;
   den_vec_type      s3_den_ff, s3_den_in;

   logic             dv_valid_ff [0:QuoW];
   meta_type         dv_meta_ff  [0:QuoW];
   rem_vec_type      dv_rem_ff   [0:QuoW];
   den_vec_type      dv_den_ff   [0:QuoW];
   quo_vec_type      dv_quo_ff   [0:QuoW];
   rem_vec_type      dv_rem_in   [0:QuoW-1];
   quo_vec_type      dv_quo_in   [0:QuoW-1];
   rem_vec_type      dv0_num_in;

   logic             rsp_valid_ff;
   logic             rsp_dir_ff;
   logic [31:0]      rsp_data_ff, rsp_data_in;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = {31'b0, dir_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= DirToHsv;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         dir_ff <= csr_pwdata[0];
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_dir_ff <= dir_ff;
         s1_c0_ff  <= req_tdata[7:0];
         s1_c1_ff  <= req_tdata[15:8];
         s1_c2_ff  <= req_tdata[23:16];
         s1_a_ff   <= req_tdata[31:24];
      end
   end

   // min/max, hue numerator, hsv sector
   always_comb begin
      logic [ChanW-1:0] mx, mn, d;
      logic [10:0]      h6;
      logic [2:0]       sec;
      mx = s1_c0_ff;
      mn = s1_c0_ff;
      if (s1_c1_ff > mx) mx = s1_c1_ff;
      if (s1_c2_ff > mx) mx = s1_c2_ff;
      if (s1_c1_ff < mn) mn = s1_c1_ff;
      if (s1_c2_ff < mn) mn = s1_c2_ff;
      d = mx - mn;
      if (s1_c0_ff == mx) begin
         if (s1_c1_ff >= s1_c2_ff) begin
            s2_n_in = {3'b0, s1_c1_ff - s1_c2_ff};
         end else begin
            s2_n_in = 11'(6 * d) - {3'b0, s1_c2_ff - s1_c1_ff};
         end
      end else if (s1_c1_ff == mx) begin
         s2_n_in = 11'(2 * d) + {3'b0, s1_c2_ff} - {3'b0, s1_c0_ff};
      end else begin
         s2_n_in = 11'(4 * d) + {3'b0, s1_c0_ff} - {3'b0, s1_c1_ff};
      end
      h6  = {1'b0, s1_c0_ff, 2'b0} + {2'b0, s1_c0_ff, 1'b0};
      sec = 3'd0;
      for (int i = 1; i <= 6; i++) begin
         if (h6 >= 11'(i * 255)) sec = 3'(i);
      end
      s2_f_in  = 8'(h6 - 11'(sec) * 11'd255);
      s2_d_in  = d;
      s2_mx_in = mx;
      s2_meta_in.dir    = s1_dir_ff;
      s2_meta_in.zero   = (s1_dir_ff == DirToHsv) ? (d == '0) : (s1_c1_ff == '0);
      s2_meta_in.v      = (s1_dir_ff == DirToHsv) ? mx : s1_c2_ff;
      s2_meta_in.sector = sec;
      s2_meta_in.alpha  = s1_a_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_meta_ff <= s2_meta_in;
         s2_n_ff    <= s2_n_in;
         s2_d_ff    <= s2_d_in;
         s2_mx_ff   <= s2_mx_in;
         s2_s_ff    <= s1_c1_ff;
         s2_f_ff    <= s2_f_in;
      end
   end

   // first products
   always_comb begin
      if (s2_meta_ff.dir == DirToHsv) begin
         s3_num_in[0] = RemW'({s2_n_ff, 8'b0} - {8'b0, s2_n_ff});
         s3_den_in[0] = DenW'(6 * s2_d_ff);
         s3_num_in[1] = RemW'({s2_d_ff, 8'b0} - {8'b0, s2_d_ff});
         s3_den_in[1] = DenW'(s2_mx_ff);
         s3_num_in[2] = '0;
         s3_den_in[2] = DenW'(1);
      end else begin
         s3_num_in[0] = RemW'(s2_meta_ff.v) * RemW'(8'd255 - s2_s_ff);
         s3_den_in[0] = Den255;
         s3_num_in[1] = RemW'(s2_s_ff) * RemW'(s2_f_ff);
         s3_den_in[1] = Den65025;
         s3_num_in[2] = RemW'(s2_s_ff) * RemW'(8'd255 - s2_f_ff);
         s3_den_in[2] = Den65025;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_meta_ff <= s2_meta_ff;
         s3_num_ff  <= s3_num_in;
         s3_den_ff  <= s3_den_in;
      end
   end

   // second products for q and t
   always_comb begin
      dv0_num_in = s3_num_ff;
      if (s3_meta_ff.dir == DirToRgb) begin
         for (int l = 1; l < NumLanes; l++) begin
            dv0_num_in[l] = RemW'(s3_meta_ff.v)
                          * RemW'(Den65025 - s3_num_ff[l][DenW-1:0]);
         end
      end
   end

   // restoring divider, one quotient bit per stage
   always_comb begin
      for (int k = 0; k < QuoW; k++) begin
         for (int l = 0; l < NumLanes; l++) begin
            logic [RemW:0] sub;
            sub = {1'b0, dv_rem_ff[k][l]}
                - ({{(RemW+1-DenW){1'b0}}, dv_den_ff[k][l]} << (QuoW - 1 - k));
            if (!sub[RemW]) begin
               dv_rem_in[k][l] = sub[RemW-1:0];
               dv_quo_in[k][l] = {dv_quo_ff[k][l][QuoW-2:0], 1'b1};
            end else begin
               dv_rem_in[k][l] = dv_rem_ff[k][l];
               dv_quo_in[k][l] = {dv_quo_ff[k][l][QuoW-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QuoW; k++) dv_valid_ff[k] <= 1'b0;
      end else if (en) begin
         dv_valid_ff[0] <= s3_valid_ff;
         for (int k = 0; k < QuoW; k++) dv_valid_ff[k+1] <= dv_valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_meta_ff[0] <= s3_meta_ff;
         dv_rem_ff[0]  <= dv0_num_in;
         dv_den_ff[0]  <= s3_den_ff;
         dv_quo_ff[0]  <= '0;
         for (int k = 0; k < QuoW; k++) begin
            dv_meta_ff[k+1] <= dv_meta_ff[k];
            dv_rem_ff[k+1]  <= dv_rem_in[k];
            dv_den_ff[k+1]  <= dv_den_ff[k];
            dv_quo_ff[k+1]  <= dv_quo_in[k];
         end
      end
   end

   // output select
   always_comb begin
      meta_type         m;
      logic [ChanW-1:0] p, q, t, o0, o1, o2, oa;
      m  = dv_meta_ff[QuoW];
      p  = dv_quo_ff[QuoW][0];
      q  = dv_quo_ff[QuoW][1];
      t  = dv_quo_ff[QuoW][2];
      oa = m.alpha;
      if (m.dir == DirToHsv) begin
         o0 = m.zero ? '0 : p;
         o1 = m.zero ? '0 : q;
         o2 = m.v;
      end else if (m.zero) begin
         o0 = m.v;
         o1 = m.v;
         o2 = m.v;
      end else begin
         case (m.sector)
            3'd0: begin o0 = m.v; o1 = t;   o2 = p;   end
            3'd1: begin o0 = q;   o1 = m.v; o2 = p;   end
            3'd2: begin o0 = p;   o1 = m.v; o2 = t;   end
            3'd3: begin o0 = p;   o1 = q;   o2 = m.v; end
            3'd4: begin o0 = t;   o1 = p;   o2 = m.v; end
            3'd5: begin o0 = m.v; o1 = p;   o2 = q;   end
            default: begin o0 = '0; o1 = '0; o2 = '0; oa = '0; end
         endcase
      end
      rsp_data_in = {oa, o2, o1, o0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid_ff[QuoW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
         rsp_dir_ff  <= dv_meta_ff[QuoW].dir;
      end
   end

   a_ready_tracks_output: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("request ready does not follow output stall");

   a_hue_below_full_turn: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_dir_ff == DirToHsv |-> rsp_tdata[7:0] != 8'd255)
      else $error("hue reached a full turn");

   a_divider_remainder: assert property (@(posedge clock) disable iff (reset)
      dv_valid_ff[QuoW] && !dv_meta_ff[QuoW].zero |->
         dv_rem_ff[QuoW][0] < RemW'(dv_den_ff[QuoW][0])
         && dv_rem_ff[QuoW][1] < RemW'(dv_den_ff[QuoW][1]))
      else $error("divider remainder not below divisor");

   a_csr_write_lands: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite |=> csr_prdata[0] == $past(csr_pwdata[0]))
      else $error("direction write lost");

endmodule

FILE: dv/rhc_checker.sv
`timescale 1ns / 1ps
module rhc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending_pixels
);
   import rhc_pkg::*;

   localparam logic [1:0] AddrDirection = 2'd0;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] third;
      logic [7:0] second;
      logic [7:0] first;
   } pixel_type;

   logic      direction;
   pixel_type expected_pixels[$];

   function automatic pixel_type convert_pixel(logic dir, pixel_type px);
      int unsigned c0, c1, c2, mx, mn, d, n, h6, sector, f, p, q, t;
      pixel_type res;
      c0 = 32'(px.first);
      c1 = 32'(px.second);
      c2 = 32'(px.third);
      res.alpha = px.alpha;
      if (dir == DirToHsv) begin
         mx = c0; mn = c0;
         if (c1 > mx) mx = c1;
         if (c2 > mx) mx = c2;
         if (c1 < mn) mn = c1;
         if (c2 < mn) mn = c2;
         d = mx - mn;
         res.third = mx[7:0];
         if (d == 0) begin
            res.first = '0;
            res.second = '0;
         end else begin
            if (c0 == mx) n = (c1 >= c2) ? c1 - c2 : 6 * d - (c2 - c1);
            else if (c1 == mx) n = 2 * d + c2 - c0;
            else n = 4 * d + c0 - c1;
            res.first = 8'((255 * n) / (6 * d));
            res.second = 8'((255 * d) / mx);
         end
      end else if (c1 == 0) begin
         res.first = c2[7:0]; res.second = c2[7:0]; res.third = c2[7:0];
      end else begin
         h6 = 6 * c0;
         sector = h6 / 255;
         f = h6 % 255;
         p = (c2 * (255 - c1)) / 255;
         q = (c2 * (65025 - c1 * f)) / 65025;
         t = (c2 * (65025 - c1 * (255 - f))) / 65025;
         case (sector)
            0: begin res.first = c2[7:0]; res.second = t[7:0]; res.third = p[7:0]; end
            1: begin res.first = q[7:0]; res.second = c2[7:0]; res.third = p[7:0]; end
            2: begin res.first = p[7:0]; res.second = c2[7:0]; res.third = t[7:0]; end
            3: begin res.first = p[7:0]; res.second = q[7:0]; res.third = c2[7:0]; end
            4: begin res.first = t[7:0]; res.second = p[7:0]; res.third = c2[7:0]; end
            5: begin res.first = c2[7:0]; res.second = p[7:0]; res.third = q[7:0]; end
            default: res = '0;
         endcase
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   assign pending_pixels = expected_pixels.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      pixel_type got, want;
      if (reset) begin
         direction <= DirToHsv;
         expected_pixels.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == AddrDirection)
            direction <= csr_pwdata[0];
         if (req_tvalid && req_tready)
            expected_pixels.push_back(convert_pixel(direction, pixel_type'(req_tdata)));
         if (rsp_tvalid && rsp_tready) begin
            got = pixel_type'(rsp_tdata);
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected result", int'(got), 0);
            end else begin
               want = expected_pixels.pop_front();
               if (got.first != want.first) report_mismatch("out_first", got.first, want.first);
               if (got.second != want.second)
                  report_mismatch("out_second", got.second, want.second);
               if (got.third != want.third) report_mismatch("out_third", got.third, want.third);
               if (got.alpha != want.alpha) report_mismatch("alpha_out", got.alpha, want.alpha);
            end
         end
      end
   end
endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import rhc_pkg::*;

   localparam int CycleLimit = 400000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [1:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending_pixels;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_cycles = 0;
   int          cycle_count = 0;

   always #6 clock = ~clock;

   rgb_hsv_color_convert dut (.*);

   rhc_checker checker_inst (.*);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("rgb_hsv_color_convert test failed");
         $finish;
      end
   end

   // receiver with random stall and long hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic write_direction(logic dir);
      @(negedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_paddr <= 2'd0;
      csr_pwdata <= {$urandom} & 32'hFFFF_FFFE | 32'(dir);
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   task automatic send_pixel(logic [31:0] px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending_pixels != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   function automatic logic [31:0] random_pixel(logic dir);
      logic [31:0] px;
      px = $urandom;
      case ($urandom_range(7))
         0: px[23:16] = px[15:8];
         1: px[15:8] = px[7:0];
         2: px[15:8] = '0;
         3: if (dir == DirToRgb) px[7:0] = 8'd255;
         default: ;
      endcase
      return px;
   endfunction

   task automatic directed_pixels();
      send_pixel(32'h0000_0000);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'hAA80_8080);
      send_pixel(32'h1100_00FF);
      send_pixel(32'h2200_FF00);
      send_pixel(32'h33FF_0000);
      send_pixel(32'h44FF_00FF);
      send_pixel(32'h55FF_FF00);
      send_pixel(32'h6600_FFFF);
      send_pixel(32'h7710_20FF);
      send_pixel(32'h88FF_0110);
      send_pixel(32'h9901_FF00);
      send_pixel(32'hCCC8_FF2A);
      send_pixel(32'hDD55_AA2B);
      send_pixel(32'hEE01_0180);
   endtask

   task automatic random_phase(logic dir, int count);
      write_direction(dir);
      for (int i = 0; i < count; i++) send_pixel(random_pixel(dir));
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      directed_pixels();
      drain();
      write_direction(DirToRgb);
      directed_pixels();
      drain();
      send_idle_pct = 16; recv_idle_pct = 80;
      random_phase(DirToHsv, 250);
      random_phase(DirToRgb, 250);
      send_idle_pct = 80; recv_idle_pct = 16;
      random_phase(DirToRgb, 250);
      random_phase(DirToHsv, 250);
      send_idle_pct = 0; recv_idle_pct = 0;
      write_direction(DirToRgb);
      hold_cycles = 60;
      for (int i = 0; i < 250; i++) send_pixel(random_pixel(DirToRgb));
      drain();
      random_phase(DirToHsv, 250);
      drain();
      if (fail_count == 0) begin
         $display("rgb_hsv_color_convert test passed");
      end else begin
         $display("rgb_hsv_color_convert test failed");
      end
      $finish;
   end
endmodule
